// File: design/hci_uart_h4_deframer_defines.svh
// Assertion macros for the H4 receive deframer.
// Stand-alone header; included by the top level, which supplies i_clk and i_rst_n.
`ifndef HCI_UART_H4_DEFRAMER_DEFINES_SVH
`define HCI_UART_H4_DEFRAMER_DEFINES_SVH

// Same-cycle implication, muted while reset is held.
`define H4_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, muted while reset is held.
`define H4_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/hci_h4_pkg.sv
// Shared types and constants for the H4 receive deframer.
// No dependencies; imported by every module of the block.
package hci_h4_pkg;

    localparam int unsigned ApbAddrW = 3;
    localparam int unsigned ApbDataW = 32;
    localparam int unsigned LenW     = 16;

    // Word index of the max_payload register (paddr[ApbAddrW-1:2]).
    localparam logic [ApbAddrW-3:0] REG_MAX_PAYLOAD = '0;

    localparam logic [LenW-1:0] MAX_PAYLOAD_RESET = 16'd1015;

    // One result per received byte.
    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       pkt_kind;
        logic       first_flag;
        logic       last_flag;
        logic       dropped_flag;
        logic       too_long;
    } t_h4_result;

endpackage

// File: design/hci_uart_h4_deframer.sv
// HCI UART (H4) receive deframer. Each request on the rx channel carries one
// byte from the serial link; each request on the result channel returns that
// byte unchanged with its framing marks: packet kind (event or ACL data),
// first byte, last byte, dropped (unknown type byte, not part of a packet)
// and too_long (payload length above max_payload, marked from the last
// header byte to the end of the packet). A zero-length packet ends on its
// last header byte. Throughput is one byte per clock while the consumer
// does not stall the result channel: a byte sits in the input register,
// the framing state machine steps on it and the marks land in the result
// register. A byte in the input register is stepped once the result
// register is empty or being drained, and its result then waits in the
// result register. The input register frees up whenever the result
// register is empty or being drained, so a stalled consumer backs up at
// most two bytes. max_payload (reset 1015) sits at byte address 0 of the
// APB-style port; write it only while no byte is in flight.
`include "hci_uart_h4_deframer_defines.svh"

module hci_uart_h4_deframer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Received byte channel
    input  logic                                i_rx_valid,
    output logic                                o_rx_ready,
    input  logic [7:0]                          i_rx_byte,
    // Result channel
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic                                o_out_valid,
    output logic [7:0]                          o_out_byte,
    output logic                                o_pkt_kind,
    output logic                                o_first_flag,
    output logic                                o_last_flag,
    output logic                                o_dropped_flag,
    output logic                                o_too_long,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hci_h4_pkg::ApbAddrW-1:0]     paddr,
    input  logic [hci_h4_pkg::ApbDataW-1:0]     pwdata,
    output logic [hci_h4_pkg::ApbDataW-1:0]     prdata,
    output logic                                pready
);
    import hci_h4_pkg::*;

    logic            r_in_vld;
    logic [7:0]      r_in_byte;
    logic            r_res_vld;
    t_h4_result      r_res;

    logic            w_advance;
    logic            w_rx_take;
    logic [LenW-1:0] w_max_payload;
    t_h4_result      w_result;

    // Terms for the checks at the end.
    logic            w_long_out;
    logic            w_long_ok;
    logic            w_cfg_wr;
    logic [LenW-1:0] w_cfg_val;

    // Step the state machine when a byte is held and the result slot is free.
    assign w_advance  = r_in_vld && (!r_res_vld || i_res_ready);
    assign o_rx_ready = !r_in_vld || w_advance;
    assign w_rx_take  = i_rx_valid && o_rx_ready;

    hci_h4_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_max_payload (w_max_payload)
    );

    hci_h4_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_advance),
        .i_byte        (r_in_byte),
        .i_max_payload (w_max_payload),
        .o_result      (w_result)
    );

    // Input register: fill on accept, empty when the byte moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_rx_take) begin
            r_in_vld <= 1'b1;
        end else if (w_advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rx_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Result register: hold until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (w_advance) begin
            r_res_vld <= 1'b1;
        end else if (i_res_ready) begin
            r_res_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_res <= w_result;
        end
    end

    assign o_res_valid    = r_res_vld;
    assign o_out_valid    = r_res.out_valid;
    assign o_out_byte     = r_res.out_byte;
    assign o_pkt_kind     = r_res.pkt_kind;
    assign o_first_flag   = r_res.first_flag;
    assign o_last_flag    = r_res.last_flag;
    assign o_dropped_flag = r_res.dropped_flag;
    assign o_too_long     = r_res.too_long;

    assign w_long_out = o_res_valid && o_too_long;
    assign w_long_ok  = o_out_valid && !o_first_flag && !o_dropped_flag;
    assign w_cfg_wr   = psel && penable && pwrite && (paddr[ApbAddrW-1:2] == REG_MAX_PAYLOAD);
    assign w_cfg_val  = pwdata[LenW-1:0];

    // A stepped byte must show up as a pending result on the next cycle.
    `H4_ASSERT_NEXT(a_step_gives_result, w_advance, o_res_valid, "stepped byte gave no result")

    // too_long only marks kept bytes past the type byte.
    `H4_ASSERT_NOW(a_too_long_kept, w_long_out, w_long_ok, "too_long on a type or dropped byte")

    // A register write lands in max_payload on the next cycle.
    `H4_ASSERT_NEXT(a_cfg_write, w_cfg_wr, w_max_payload == $past(w_cfg_val), "write lost")

endmodule

// File: design/hci_h4_regs.sv
// APB-style configuration register file for the H4 deframer.
// Depends on hci_h4_pkg; holds max_payload.
module hci_h4_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hci_h4_pkg::ApbAddrW-1:0]     paddr,
    input  logic [hci_h4_pkg::ApbDataW-1:0]     pwdata,
    output logic [hci_h4_pkg::ApbDataW-1:0]     prdata,
    output logic                                pready,
    output logic [hci_h4_pkg::LenW-1:0]         o_max_payload
);
    import hci_h4_pkg::*;

    logic [LenW-1:0]     r_max_payload;
    logic                w_sel_max;

    assign w_sel_max = (paddr[ApbAddrW-1:2] == REG_MAX_PAYLOAD);
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else if (psel && penable && pwrite && w_sel_max) begin
            r_max_payload <= pwdata[LenW-1:0];
        end
    end

    // Read path: decode the word address, zero elsewhere.
    always_comb begin
        prdata = '0;
        if (w_sel_max) begin
            prdata = {{(ApbDataW-LenW){1'b0}}, r_max_payload};
        end
    end

    assign o_max_payload = r_max_payload;

endmodule

// File: design/hci_h4_core.sv
// Per-byte framing state machine of the H4 deframer.
// Depends on hci_h4_pkg; advances one byte when i_step is high.
module hci_h4_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic [7:0]                        i_byte,
    input  logic [hci_h4_pkg::LenW-1:0]       i_max_payload,
    output hci_h4_pkg::t_h4_result            o_result
);
    import hci_h4_pkg::*;

    localparam logic [1:0] PH_TYPE    = 2'd0;
    localparam logic [1:0] PH_EVENT   = 2'd1;
    localparam logic [1:0] PH_ACL     = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    localparam logic [7:0] TYPE_EVENT = 8'h04;
    localparam logic [7:0] TYPE_ACL   = 8'h02;

    // Header byte positions that carry the length.
    localparam logic [2:0] EVT_LEN_POS = 3'd1;
    localparam logic [2:0] ACL_LO_POS  = 3'd2;
    localparam logic [2:0] ACL_HI_POS  = 3'd3;

    logic [1:0]      r_phase,   n_phase;
    logic [LenW-1:0] r_left,    n_left;
    logic [2:0]      r_hpos,    n_hpos;
    logic [7:0]      r_len_lo,  n_len_lo;
    logic            r_kind,    n_kind;
    logic            r_long,    n_long;

    logic [LenW-1:0] w_len;
    logic            w_valid, w_first, w_last, w_dropped;

    assign w_len = (r_phase == PH_EVENT) ? {8'd0, i_byte} : {i_byte, r_len_lo};

    always_comb begin
        n_phase   = r_phase;
        n_left    = r_left;
        n_hpos    = r_hpos;
        n_len_lo  = r_len_lo;
        n_kind    = r_kind;
        n_long    = r_long;
        w_valid   = 1'b1;
        w_first   = 1'b0;
        w_last    = 1'b0;
        w_dropped = 1'b0;
        case (r_phase)
            PH_TYPE: begin
                n_long = 1'b0;
                n_hpos = '0;
                n_left = '0;
                n_kind = 1'b0;
                if (i_byte == TYPE_EVENT) begin
                    n_phase = PH_EVENT;
                    w_first = 1'b1;
                end else if (i_byte == TYPE_ACL) begin
                    n_kind  = 1'b1;
                    n_phase = PH_ACL;
                    w_first = 1'b1;
                end else begin
                    w_valid   = 1'b0;
                    w_dropped = 1'b1;
                end
            end
            PH_EVENT, PH_ACL: begin
                if ((r_phase == PH_EVENT && r_hpos < EVT_LEN_POS) ||
                    (r_phase == PH_ACL && r_hpos < ACL_LO_POS)) begin
                    n_hpos = r_hpos + 3'd1;
                end else if (r_phase == PH_ACL && r_hpos == ACL_LO_POS) begin
                    n_len_lo = i_byte;
                    n_hpos   = ACL_HI_POS;
                end else begin
                    // Length complete: close the header.
                    n_long = (w_len > i_max_payload);
                    n_hpos = '0;
                    if (w_len == '0) begin
                        n_phase = PH_TYPE;
                        n_left  = '0;
                        w_last  = 1'b1;
                    end else begin
                        n_left  = w_len;
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            default: begin
                n_left = r_left - 16'd1;
                if (n_left == '0) begin
                    w_last  = 1'b1;
                    n_phase = PH_TYPE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TYPE;
            r_left   <= '0;
            r_hpos   <= '0;
            r_len_lo <= '0;
            r_kind   <= 1'b0;
            r_long   <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_left   <= n_left;
            r_hpos   <= n_hpos;
            r_len_lo <= n_len_lo;
            r_kind   <= n_kind;
            r_long   <= n_long;
        end
    end

    assign o_result.out_valid    = w_valid;
    assign o_result.out_byte     = i_byte;
    assign o_result.pkt_kind     = w_valid & n_kind;
    assign o_result.first_flag   = w_first;
    assign o_result.last_flag    = w_last;
    assign o_result.dropped_flag = w_dropped;
    assign o_result.too_long     = w_valid & n_long;

endmodule
